// ===== rtl/gpjp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, segment table and constants of the gait phase joint profile.
package gpjp_pkg;

  localparam int NUM_LEGS   = 4;
  localparam int NUM_JOINTS = 5;
  localparam int NUM_SEGS   = 5;

  typedef logic [1:0]          leg_t;
  typedef logic [15:0]         phase_t;
  typedef logic [16:0]         arg_t;
  typedef logic [2:0]          seg_t;
  typedef logic signed [15:0]  dist_t;
  typedef logic signed [18:0]  slope_t;
  typedef logic signed [24:0]  angle_t;
  typedef logic signed [34:0]  prod_t;
  typedef logic signed [31:0]  scaled_t;
  typedef logic [27:0]         quot_prod_t;
  typedef logic [11:0]         count_t;

  localparam seg_t SEG_0 = 3'd0;
  localparam seg_t SEG_1 = 3'd1;
  localparam seg_t SEG_2 = 3'd2;
  localparam seg_t SEG_3 = 3'd3;
  localparam seg_t SEG_4 = 3'd4;

  localparam arg_t BREAK_1 = 17'd13107;
  localparam arg_t BREAK_2 = 17'd28180;
  localparam arg_t BREAK_3 = 17'd43254;
  localparam arg_t BREAK_4 = 17'd59630;

  localparam arg_t ARG_FULL = 17'd65536;

  localparam arg_t SEG_ORIGIN [NUM_SEGS] = '{17'd0, 17'd13107, 17'd28180, 17'd43254, 17'd59638};

  // Q8.16 degrees
  localparam angle_t SEG_BASE [NUM_SEGS][NUM_JOINTS] = '{
    '{ 25'sd1146880,  25'sd0,        25'sd0,        25'sd0,        25'sd0       },
    '{-25'sd2097152,  25'sd950272,   25'sd0,        25'sd0,        25'sd0       },
    '{ 25'sd1146880, -25'sd1900544,  25'sd950272,   25'sd0,        25'sd0       },
    '{ 25'sd0,        25'sd950272,  -25'sd1835008,  25'sd851968,   25'sd0       },
    '{ 25'sd0,        25'sd0,        25'sd950272,  -25'sd3276800,  25'sd2424832 }
  };

  // degrees per phase unit, 24 fraction bits
  localparam slope_t SEG_SLOPE [NUM_SEGS][NUM_JOINTS] = '{
    '{-19'sd63224,  19'sd18531,  19'sd0,      19'sd0,       19'sd0      },
    '{ 19'sd54977, -19'sd48343,  19'sd16114,  19'sd0,       19'sd0      },
    '{-19'sd19430,  19'sd48340, -19'sd47077,  19'sd14850,   19'sd0      },
    '{ 19'sd0,     -19'sd14825,  19'sd43313, -19'sd65080,   19'sd37755  },
    '{ 19'sd49659,  19'sd0,     -19'sd41182,  19'sd142832, -19'sd104879 }
  };

  // ceil(65536 / 11), exact quotient for 15-bit dividends
  localparam logic [12:0] RECIP_11 = 13'd5958;
  localparam count_t      COUNT_ZERO = 12'd2048;

  localparam logic [7:0]  STEP_SCALE_RESET = 8'd40;
  localparam logic        REG_STEP_SCALE = 1'b0;

endpackage

// ===== rtl/gait_phase_joint_profile.sv =====
`timescale 1ns / 1ps
// Four-leg gait phase generator with piecewise-linear joint profile and servo counts.
// Throughput: one leg result per cycle unless the output stalls, set by the leg sequencer.
// Order: the input transfer loads the leg sequencer, which issues legs 0 to 3 into the pipeline in turn.
// Pipeline: leg phase/segment, profile products, angle scale, divide by 11, servo count.
// A stalled output holds the whole pipeline; an input transfer is taken while leg 3 issues or the sequencer is idle.
// Reset (rst, synchronous): phases zero, step_scale 40, pipeline empty.
module gait_phase_joint_profile
  import gpjp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               drive_valid,
  output logic               drive_ready,
  input  logic signed [15:0] drive_velocity,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         leg_index,
  output logic [15:0]        leg_phase,
  output logic [11:0]        servo_joint0,
  output logic [11:0]        servo_joint1,
  output logic [11:0]        servo_joint2,
  output logic [11:0]        servo_joint3,
  output logic [11:0]        servo_joint4,
  output logic               last_leg
);

  localparam leg_t LAST_LEG = leg_t'(NUM_LEGS - 1);

  logic [7:0]  step_scale;
  phase_t      phase_store [NUM_LEGS];

  logic        advance;
  logic        item_valid;
  phase_t      adv;
  leg_t        leg;

  logic        s1_valid;
  leg_t        s1_leg;
  phase_t      s1_phase;
  seg_t        s1_seg;
  dist_t       s1_d;

  logic        s2_valid;
  leg_t        s2_leg;
  phase_t      s2_phase;
  seg_t        s2_seg;
  prod_t       s2_prod [NUM_JOINTS];

  logic        s3_valid;
  leg_t        s3_leg;
  phase_t      s3_phase;
  scaled_t     s3_scaled [NUM_JOINTS];

  logic        s4_valid;
  leg_t        s4_leg;
  phase_t      s4_phase;
  logic        s4_neg [NUM_JOINTS];
  quot_prod_t  s4_qprod [NUM_JOINTS];

  logic        out_valid;
  leg_t        out_leg;
  phase_t      out_phase;
  count_t      out_count [NUM_JOINTS];

  logic        cfg_write;
  logic [24:0] adv_full;
  phase_t      phase_next;
  arg_t        arg;
  seg_t        seg_next;
  logic signed [17:0] d_full;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_STEP_SCALE) ? {24'd0, step_scale} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale <= STEP_SCALE_RESET;
    end else if (cfg_write && paddr[2] == REG_STEP_SCALE) begin
      step_scale <= pwdata[7:0];
    end
  end

  // input and leg sequencer
  assign advance     = !out_valid || result_ready;
  assign drive_ready = advance && (!item_valid || leg == LAST_LEG);
  assign adv_full    = drive_velocity * $signed({1'b0, step_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      leg        <= '0;
    end else if (advance) begin
      if (drive_valid && drive_ready) begin
        item_valid <= 1'b1;
        leg        <= '0;
      end else if (item_valid) begin
        if (leg == LAST_LEG) begin
          item_valid <= 1'b0;
        end
        leg <= leg + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drive_valid && drive_ready) begin
      adv <= adv_full[15:0];
    end
  end

  // leg phase and segment
  always_comb begin
    phase_next = phase_store[leg] + adv;
    arg = leg[1] ? (ARG_FULL - {1'b0, phase_next}) : {1'b0, phase_next};
    priority if (arg < BREAK_1) seg_next = SEG_0;
    else if (arg < BREAK_2)     seg_next = SEG_1;
    else if (arg < BREAK_3)     seg_next = SEG_2;
    else if (arg < BREAK_4)     seg_next = SEG_3;
    else                        seg_next = SEG_4;
    d_full = $signed({1'b0, arg}) - $signed({1'b0, SEG_ORIGIN[seg_next]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        phase_store[i] <= '0;
      end
    end else if (advance && item_valid) begin
      phase_store[leg] <= phase_next;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= item_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_leg   <= leg;
      s1_phase <= phase_next;
      s1_seg   <= seg_next;
      s1_d     <= d_full[15:0];

      s2_leg   <= s1_leg;
      s2_phase <= s1_phase;
      s2_seg   <= s1_seg;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        s2_prod[j] <= prod_t'(SEG_SLOPE[s1_seg][j]) * prod_t'(s1_d);
      end

      s3_leg   <= s2_leg;
      s3_phase <= s2_phase;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        s3_scaled[j] <= scale_angle(s2_prod[j], SEG_BASE[s2_seg][j],
                                    (j < NUM_JOINTS - 1) ? (s2_leg == 2'd0 || s2_leg == LAST_LEG)
                                                         : (s2_leg == 2'd1 || s2_leg == 2'd2));
      end

      s4_leg   <= s3_leg;
      s4_phase <= s3_phase;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        s4_neg[j]   <= s3_scaled[j][31];
        s4_qprod[j] <= quot_prod_t'(mag_high(s3_scaled[j])) * quot_prod_t'(RECIP_11);
      end

      out_leg   <= s4_leg;
      out_phase <= s4_phase;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        out_count[j] <= s4_neg[j] ? (COUNT_ZERO - s4_qprod[j][27:16])
                                  : (COUNT_ZERO + s4_qprod[j][27:16]);
      end
    end
  end

  // round the product, add the segment base, apply the leg sign, times 125
  function automatic scaled_t scale_angle(prod_t p, angle_t base, logic neg);
    prod_t   rnd;
    angle_t  ang;
    scaled_t x;
    rnd = (p + 35'sd128) >>> 8;
    ang = base + $signed(rnd[24:0]);
    if (neg) begin
      ang = -ang;
    end
    x = scaled_t'(ang);
    return (x <<< 7) - (x <<< 2) + x;
  endfunction

  // magnitude divided by 65536
  function automatic logic [14:0] mag_high(scaled_t x);
    logic [31:0] m;
    m = x[31] ? 32'(-x) : 32'(x);
    return m[30:16];
  endfunction

  assign result_valid = out_valid;
  assign leg_index    = out_leg;
  assign leg_phase    = out_phase;
  assign servo_joint0 = out_count[0];
  assign servo_joint1 = out_count[1];
  assign servo_joint2 = out_count[2];
  assign servo_joint3 = out_count[3];
  assign servo_joint4 = out_count[4];
  assign last_leg     = (out_leg == LAST_LEG);

  a_accept_on_last_leg: assert property (@(posedge clk) disable iff (rst)
    drive_valid && drive_ready |-> !item_valid || leg == LAST_LEG)
    else $error("input transfer while legs of a tick remain");

  a_sequencer_holds: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(leg) && $stable(adv))
    else $error("leg sequencer moved during stall");

  a_legs_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && leg_index != LAST_LEG |->
      s4_valid && s4_leg == leg_index + 2'd1)
    else $error("leg results of a tick not consecutive");

endmodule

// ===== dv/gait_phase_joint_profile_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts the four leg results of every drive tick, compares them as they leave and checks step_scale reads.
module gait_phase_joint_profile_checker
  import gpjp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               drive_valid,
  input  logic               drive_ready,
  input  logic signed [15:0] drive_velocity,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic [1:0]         leg_index,
  input  logic [15:0]        leg_phase,
  input  logic [11:0]        servo_joint0,
  input  logic [11:0]        servo_joint1,
  input  logic [11:0]        servo_joint2,
  input  logic [11:0]        servo_joint3,
  input  logic [11:0]        servo_joint4,
  input  logic               last_leg,
  output int                 mismatch_count,
  output int                 results_due
);

  localparam logic [2:0] ADDR_STEP_SCALE = {REG_STEP_SCALE, 2'b00};

  localparam int SEG_LIMIT [4] = '{13107, 28180, 43254, 59630};
  localparam int SEG_START [5] = '{0, 13107, 28180, 43254, 59638};

  localparam int PROFILE_BASE [5][5] = '{
    '{ 1146880,        0,        0,        0,       0},
    '{-2097152,   950272,        0,        0,       0},
    '{ 1146880, -1900544,   950272,        0,       0},
    '{       0,   950272, -1835008,   851968,       0},
    '{       0,        0,   950272, -3276800, 2424832}
  };

  localparam int PROFILE_SLOPE [5][5] = '{
    '{-63224,  18531,      0,      0,       0},
    '{ 54977, -48343,  16114,      0,       0},
    '{-19430,  48340, -47077,  14850,       0},
    '{     0, -14825,  43313, -65080,   37755},
    '{ 49659,      0, -41182, 142832, -104879}
  };

  typedef struct packed {
    leg_t                          leg;
    phase_t                        phase;
    logic [NUM_JOINTS-1:0][11:0]   joints;
    logic                          is_last;
  } leg_result_t;

  leg_result_t leg_results_due [$];
  phase_t      leg_phases [NUM_LEGS];
  logic [7:0]  drive_scale;

  function automatic leg_result_t leg_profile(input int leg, input phase_t ph);
    int          arg;
    int          seg;
    int          delta;
    longint      prod;
    longint      ang;
    longint      off;
    bit          flip;
    leg_result_t r;
    arg = (leg >= 2) ? 65536 - int'(ph) : int'(ph);
    seg = 0;
    for (int k = 0; k < 4; k++) begin
      if (arg >= SEG_LIMIT[k]) seg = k + 1;
    end
    delta = arg - SEG_START[seg];
    r.leg = 2'(leg);
    r.phase = ph;
    r.is_last = (leg == NUM_LEGS - 1);
    for (int j = 0; j < NUM_JOINTS; j++) begin
      prod = longint'(PROFILE_SLOPE[seg][j]) * longint'(delta);
      ang = longint'(PROFILE_BASE[seg][j]) + ((prod + 64'sd128) >>> 8);
      flip = (j < 4) ? (leg == 0 || leg == 3) : (leg == 1 || leg == 2);
      if (flip) ang = -ang;
      off = (ang * 125) / 720896;
      r.joints[j] = 12'(2048 + off);
    end
    return r;
  endfunction

  function automatic string show(input leg_result_t r);
    return $sformatf("leg %0d phase %0d joints %0d %0d %0d %0d %0d last %0d",
                     r.leg, r.phase, r.joints[0], r.joints[1], r.joints[2],
                     r.joints[3], r.joints[4], r.is_last);
  endfunction

  task automatic flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : track
    leg_result_t got;
    leg_result_t want;
    int          vel;
    phase_t      adv;
    if (rst) begin
      leg_results_due.delete();
      drive_scale = STEP_SCALE_RESET;
      for (int i = 0; i < NUM_LEGS; i++) leg_phases[i] = '0;
      mismatch_count = 0;
    end else begin
      if (psel && penable && pready && pwrite && paddr == ADDR_STEP_SCALE)
        drive_scale = pwdata[7:0];
      if (psel && penable && pready && !pwrite && paddr == ADDR_STEP_SCALE &&
          prdata[7:0] != drive_scale)
        flag($sformatf("step_scale read expected %0d got %0d", drive_scale, prdata[7:0]));
      if (result_valid && result_ready) begin
        got.leg = leg_index;
        got.phase = leg_phase;
        got.joints[0] = servo_joint0;
        got.joints[1] = servo_joint1;
        got.joints[2] = servo_joint2;
        got.joints[3] = servo_joint3;
        got.joints[4] = servo_joint4;
        got.is_last = last_leg;
        if (leg_results_due.size() == 0) begin
          flag($sformatf("unexpected result %s", show(got)));
        end else begin
          want = leg_results_due.pop_front();
          if (got != want)
            flag($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
      if (drive_valid && drive_ready) begin
        vel = int'(drive_velocity);
        adv = 16'(vel * int'(drive_scale));
        for (int leg = 0; leg < NUM_LEGS; leg++) begin
          leg_phases[leg] = leg_phases[leg] + adv;
          leg_results_due.push_back(leg_profile(leg, leg_phases[leg]));
        end
      end
    end
    results_due <= leg_results_due.size();
  end

endmodule

// ===== dv/gait_phase_joint_profile_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives drive ticks and register writes into the block and reports the verdict.
module gait_phase_joint_profile_test;
  import gpjp_pkg::*;

  localparam logic [2:0] ADDR_STEP_SCALE = {REG_STEP_SCALE, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         HOLD_CYCLES     = 200;
  localparam int         DRAIN_CYCLES    = 16;
  localparam int         PHASE_TICKS     = 80;

  localparam logic [15:0] STEER_TARGETS [10] = '{
    16'd59630, 16'd59637, 16'd59638, 16'd5906, 16'd5899,
    16'd13107, 16'd13106, 16'd28180, 16'd43254, 16'd65535
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               drive_valid;
  logic               drive_ready;
  logic signed [15:0] drive_velocity;
  logic               result_valid;
  logic               result_ready;
  logic [1:0]         leg_index;
  logic [15:0]        leg_phase;
  logic [11:0]        servo_joint0;
  logic [11:0]        servo_joint1;
  logic [11:0]        servo_joint2;
  logic [11:0]        servo_joint3;
  logic [11:0]        servo_joint4;
  logic               last_leg;

  int         mismatch_count;
  int         results_due;
  int         cycle_count = 0;
  int         hold_count = 0;
  int         ticks_sent = 0;
  int         cfg_writes = 0;
  logic [7:0] cur_scale = STEP_SCALE_RESET;
  phase_t     dir_phase = '0;

  gait_phase_joint_profile dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .drive_valid, .drive_ready, .drive_velocity,
    .result_valid, .result_ready, .leg_index, .leg_phase,
    .servo_joint0, .servo_joint1, .servo_joint2, .servo_joint3, .servo_joint4,
    .last_leg
  );

  gait_phase_joint_profile_checker leg_check (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .drive_valid, .drive_ready, .drive_velocity,
    .result_valid, .result_ready, .leg_index, .leg_phase,
    .servo_joint0, .servo_joint1, .servo_joint2, .servo_joint3, .servo_joint4,
    .last_leg, .mismatch_count, .results_due
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic signed [15:0] v);
    drive_valid <= 1'b1;
    drive_velocity <= v;
    do @(posedge clk); while (!drive_ready);
    dir_phase = dir_phase + 16'(int'(v) * int'(cur_scale));
    ticks_sent++;
  endtask

  // optional write while idle, then read back step_scale
  task automatic program_register(input bit do_write, input logic [2:0] addr,
                                  input logic [31:0] data);
    if (do_write) begin
      drive_valid <= 1'b0;
      do @(posedge clk); while (results_due != 0);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (addr == ADDR_STEP_SCALE) cur_scale = data[7:0];
      cfg_writes++;
    end
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_STEP_SCALE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : receiver
    int mode;
    int mode_left;
    int hold_seen;
    int beat;
    mode = 0;
    mode_left = 0;
    hold_seen = 0;
    beat = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_count != hold_seen) begin
        hold_seen = hold_count;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        beat++;
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= (beat % 4 == 0);
          default: result_ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int                 sent;
    int                 burst;
    logic signed [15:0] vel;
    logic [7:0]         scale_pick;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    drive_valid = 1'b0;
    drive_velocity = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset value, zero phase on every leg, velocity extremes
    program_register(1'b0, ADDR_STEP_SCALE, '0);
    send_tick(16'sd0);
    send_tick(16'sh7FFF);
    send_tick(-16'sh8000);
    send_tick(16'sd1);
    send_tick(-16'sd1);

    // steer the phase onto segment breaks and the break/origin gap
    program_register(1'b1, ADDR_STEP_SCALE, 32'd1);
    for (int i = 0; i < 10; i++) send_tick(16'(STEER_TARGETS[i] - dir_phase));

    program_register(1'b1, ADDR_STEP_SCALE, 32'd255);
    send_tick(16'sh7FFF);
    send_tick(-16'sh8000);

    // zero scale holds every phase
    program_register(1'b1, ADDR_STEP_SCALE, 32'd0);
    send_tick(16'sh1234);
    program_register(1'b1, ADDR_UNUSED, 32'hFFFF_FFAB);
    send_tick(-16'sd12345);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: scale_pick = 8'd1;
        1: scale_pick = 8'd255;
        2: scale_pick = 8'($urandom_range(2, 254));
        3: scale_pick = STEP_SCALE_RESET;
        default: scale_pick = 8'($urandom_range(1, 255));
      endcase
      program_register(1'b1, ADDR_STEP_SCALE, {24'($urandom()), scale_pick});
      if (ph == 3) program_register(1'b1, ADDR_UNUSED, $urandom());
      sent = 0;
      while (sent < PHASE_TICKS) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < PHASE_TICKS; b++) begin
          case ($urandom_range(0, 9))
            0: vel = 16'sh7FFF - 16'($urandom_range(0, 3));
            1: vel = 16'h8000 + 16'($urandom_range(0, 3));
            2, 3: vel = 16'(int'($urandom_range(0, 128)) - 64);
            default: vel = 16'($urandom());
          endcase
          send_tick(vel);
          sent++;
          if (ph == 1 && sent == 30) hold_count <= hold_count + 1;
          if (ph == 2 && sent == 40) begin
            drive_valid <= 1'b0;
            do @(posedge clk); while (results_due != 0);
          end
        end
        if ($urandom_range(0, 3) != 0) begin
          drive_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end

    drive_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d drive ticks and %0d register writes: segment breaks, phase wrap,",
             ticks_sent, cfg_writes);
    $display("step_scale 0, 1, 40 and 255, output stalls and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gpjp_pkg.sv
rtl/gait_phase_joint_profile.sv
dv/gait_phase_joint_profile_checker.sv
dv/gait_phase_joint_profile_test.sv
